>>> src/yaz0_lz_decompressor_assert.svh
// Assertion macros for the Yaz0 LZ decompressor.
// Expects clock aclk and active-low synchronous reset aresetn in the including scope.
`ifndef YAZ0_LZ_DECOMPRESSOR_ASSERT_SVH
`define YAZ0_LZ_DECOMPRESSOR_ASSERT_SVH

// Condition must hold at every clock edge outside reset
`define YAZ0_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define YAZ0_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> src/yaz0_pkg.sv
// Shared types and constants for the Yaz0 LZ decompressor.
// No dependencies; imported by the decompressor top level.
package yaz0_pkg;

    // Default sizing
    localparam int WINDOW_BYTES_DEF     = 4096;
    localparam int BYTES_PER_RESULT_DEF = 8;

    // Field widths
    localparam int IN_BYTE_W    = 8;
    localparam int OUT_BYTES_W  = 64;
    localparam int BYTE_COUNT_W = 4;
    localparam int SIZE_W       = 32;
    localparam int DIST_W       = 12;
    localparam int LEN_W        = 9;
    localparam int M_TDATA_W    = 72;
    localparam int M_TUSER_W    = 3;

    // Token decoding constants
    localparam logic [LEN_W-1:0] LONG_LEN_BASE  = 9'h12;
    localparam logic [LEN_W-1:0] SHORT_LEN_BASE = 9'h2;
    localparam logic [3:0]       FLAGS_PER_BYTE = 4'd8;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_DIST  = 2'd1,
        STAT_TRUNCATED = 2'd2
    } yaz0_status_t;

endpackage

>>> src/yaz0_win_ram.sv
// History window RAM: one write port, one registered read port.
// No dependencies.
module yaz0_win_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/yaz0_lz_decompressor.sv
// Yaz0 LZ decompressor. Takes one payload byte per transaction and returns decoded bytes
// in groups of up to BYTES_PER_RESULT. Flag, token and extra-length bytes are each accepted
// in S_IDLE; a literal is accepted, then its result is emitted from S_EMIT. A back-reference
// is copied one byte at a time through the single read and write port of the history RAM
// (S_COPY_RD, then S_COPY_WR for each byte), with each result emitted from S_EMIT; the
// input is held until the copy is done, and a stalled result side holds it further.
// Writing the size register (cfg_data) restarts the stream; a size of zero leaves the
// block halted. Depends on yaz0_pkg, yaz0_win_ram and yaz0_lz_decompressor_assert.svh.
`include "yaz0_lz_decompressor_assert.svh"

module yaz0_lz_decompressor #(
    parameter int WINDOW_BYTES     = yaz0_pkg::WINDOW_BYTES_DEF,
    parameter int BYTES_PER_RESULT = yaz0_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Size register write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [yaz0_pkg::SIZE_W-1:0]    cfg_data,
    // Compressed input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [yaz0_pkg::IN_BYTE_W-1:0] s_tdata,  // [7:0] in_byte
    input  logic                           s_tlast,  // last_byte
    // Decoded output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [yaz0_pkg::M_TDATA_W-1:0] m_tdata,  // [63:0] out_bytes, [67:64] byte_count
    output logic                           m_tlast,  // run_last
    output logic [yaz0_pkg::M_TUSER_W-1:0] m_tuser   // [0] stream_done, [2:1] status
);
    import yaz0_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY_RD,
        S_COPY_WR,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_ELEM,
        PH_TOK2,
        PH_EXTRA
    } phase_t;

    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic [SIZE_W-1:0]       decoded_reg, decoded_next;
    logic [SIZE_W-1:0]       produced_reg, produced_next;
    logic [7:0]              flag_bits_reg, flag_bits_next;
    logic [3:0]              flags_left_reg, flags_left_next;
    logic [7:0]              tok1_reg, tok1_next;
    logic [DIST_W-1:0]       dist_reg, dist_next;
    logic                    halted_reg, halted_next;
    logic                    last_reg, last_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [AW-1:0]           wp_reg, wp_next;
    logic [OUT_BYTES_W-1:0]  acc_reg, acc_next;
    logic [BYTE_COUNT_W-1:0] cnt_reg, cnt_next;
    logic                    emit_final_reg, emit_final_next;
    yaz0_status_t            emit_status_reg, emit_status_next;
    logic                    emit_done_reg, emit_done_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                    m_tlast_reg, m_tlast_next;
    logic [M_TUSER_W-1:0]    m_tuser_reg, m_tuser_next;

    logic                    wr_en;
    logic [7:0]              wr_data;
    logic [AW-1:0]           rd_addr;
    logic [7:0]              rd_data;
    logic [AW:0]             back;
    logic [AW:0]             back_wrap;
    logic [AW-1:0]           wp_inc;
    logic [SIZE_W-1:0]       produced_inc;
    logic                    at_end;
    logic [3:0]              flags_left_dec;
    logic [DIST_W-1:0]       tok_dist;
    logic [3:0]              tok_nib;
    logic                    copy_end;

    // History window
    yaz0_win_ram #(
        .DEPTH  (WINDOW_BYTES),
        .ADDR_W (AW)
    ) u_win_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Copy source: distance+1 bytes behind the write pointer, wrapped into the window
    assign back      = {1'b0, wp_reg} - (AW+1)'(dist_reg) - (AW+1)'(1);
    assign back_wrap = back + (AW+1)'(WINDOW_BYTES);
    assign rd_addr   = back[AW] ? back_wrap[AW-1:0] : back[AW-1:0];

    assign wp_inc         = (wp_reg == AW'(WINDOW_BYTES - 1)) ? '0 : wp_reg + AW'(1);
    assign produced_inc   = produced_reg + SIZE_W'(1);
    assign at_end         = (produced_inc == decoded_reg);
    assign flags_left_dec = (flags_left_reg != 4'd0) ? flags_left_reg - 4'd1 : 4'd0;
    assign tok_dist       = {tok1_reg[3:0], s_tdata};
    assign tok_nib        = tok1_reg[7:4];
    assign copy_end       = (len_reg == LEN_W'(1)) || at_end;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tuser   = m_tuser_reg;

    // Sequencer next state
    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        decoded_next     = decoded_reg;
        produced_next    = produced_reg;
        flag_bits_next   = flag_bits_reg;
        flags_left_next  = flags_left_reg;
        tok1_next        = tok1_reg;
        dist_next        = dist_reg;
        halted_next      = halted_reg;
        last_next        = last_reg;
        len_next         = len_reg;
        wp_next          = wp_reg;
        acc_next         = acc_reg;
        cnt_next         = cnt_reg;
        emit_final_next  = emit_final_reg;
        emit_status_next = emit_status_reg;
        emit_done_next   = emit_done_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tlast_next     = m_tlast_reg;
        m_tuser_next     = m_tuser_reg;
        wr_en            = 1'b0;
        wr_data          = s_tdata;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && !halted_reg) begin
                    case (phase_reg)
                        PH_FLAG: begin
                            flag_bits_next  = s_tdata;
                            flags_left_next = FLAGS_PER_BYTE;
                            phase_next      = PH_ELEM;
                        end
                        PH_ELEM: begin
                            flag_bits_next  = {flag_bits_reg[6:0], 1'b0};
                            flags_left_next = flags_left_dec;
                            if (flag_bits_reg[7]) begin
                                // Literal: store and emit a one-byte result
                                wr_en            = 1'b1;
                                wp_next          = wp_inc;
                                produced_next    = produced_inc;
                                acc_next         = OUT_BYTES_W'(s_tdata);
                                cnt_next         = BYTE_COUNT_W'(1);
                                emit_final_next  = 1'b1;
                                emit_done_next   = at_end;
                                emit_status_next = (!at_end && s_tlast) ? STAT_TRUNCATED
                                                                        : STAT_OK;
                                halted_next      = at_end || s_tlast;
                                phase_next       = (flags_left_dec != 4'd0) ? PH_ELEM
                                                                            : PH_FLAG;
                                state_next       = S_EMIT;
                            end else begin
                                tok1_next  = s_tdata;
                                phase_next = PH_TOK2;
                            end
                        end
                        PH_TOK2: begin
                            if (SIZE_W'(tok_dist) >= produced_reg) begin
                                // Distance reaches before the start of the output
                                phase_next = PH_TOK2;
                            end else begin
                                dist_next = tok_dist;
                                if (tok_nib == 4'd0) begin
                                    phase_next = PH_EXTRA;
                                end else begin
                                    len_next   = LEN_W'(tok_nib) + SHORT_LEN_BASE;
                                    last_next  = s_tlast;
                                    acc_next   = '0;
                                    cnt_next   = '0;
                                    state_next = S_COPY_RD;
                                end
                            end
                        end
                        default: begin
                            len_next   = LEN_W'(s_tdata) + LONG_LEN_BASE;
                            last_next  = s_tlast;
                            acc_next   = '0;
                            cnt_next   = '0;
                            state_next = S_COPY_RD;
                        end
                    endcase

                    // Bad distance or a quiet byte marked last: one empty result
                    if (phase_reg == PH_TOK2 && SIZE_W'(tok_dist) >= produced_reg) begin
                        acc_next         = '0;
                        cnt_next         = '0;
                        emit_final_next  = 1'b1;
                        emit_done_next   = 1'b0;
                        emit_status_next = STAT_BAD_DIST;
                        halted_next      = 1'b1;
                        state_next       = S_EMIT;
                    end else if (s_tlast && (phase_reg == PH_FLAG
                                 || (phase_reg == PH_ELEM && !flag_bits_reg[7])
                                 || (phase_reg == PH_TOK2 && tok_nib == 4'd0))) begin
                        acc_next         = '0;
                        cnt_next         = '0;
                        emit_final_next  = 1'b1;
                        emit_done_next   = 1'b0;
                        emit_status_next = STAT_TRUNCATED;
                        halted_next      = 1'b1;
                        state_next       = S_EMIT;
                    end
                end
            end
            S_COPY_RD: begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR: begin
                // Append the copied byte to the window and the result lanes
                wr_en         = 1'b1;
                wr_data       = rd_data;
                wp_next       = wp_inc;
                produced_next = produced_inc;
                len_next      = len_reg - LEN_W'(1);
                cnt_next      = cnt_reg + BYTE_COUNT_W'(1);
                for (int i = 0; i < BYTES_PER_RESULT; i++) begin
                    if (cnt_reg == BYTE_COUNT_W'(i)) begin
                        acc_next[8*i +: 8] = rd_data;
                    end
                end
                if (copy_end || (cnt_reg + BYTE_COUNT_W'(1) ==
                                 BYTE_COUNT_W'(BYTES_PER_RESULT))) begin
                    emit_final_next  = copy_end;
                    emit_done_next   = copy_end && at_end;
                    emit_status_next = (copy_end && !at_end && last_reg) ? STAT_TRUNCATED
                                                                         : STAT_OK;
                    state_next       = S_EMIT;
                end else begin
                    state_next = S_COPY_RD;
                end
                if (copy_end) begin
                    halted_next = at_end || last_reg;
                    phase_next  = (flags_left_reg != 4'd0) ? PH_ELEM : PH_FLAG;
                end
            end
            S_EMIT: begin
                // Load the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(M_TDATA_W - OUT_BYTES_W - BYTE_COUNT_W)'(0),
                                     cnt_reg, acc_reg};
                    m_tlast_next  = emit_final_reg;
                    m_tuser_next  = {emit_status_reg, emit_done_reg};
                    acc_next      = '0;
                    cnt_next      = '0;
                    state_next    = emit_final_reg ? S_IDLE : S_COPY_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Size write restarts the stream
        if (cfg_valid) begin
            decoded_next    = cfg_data;
            produced_next   = '0;
            phase_next      = PH_FLAG;
            flag_bits_next  = '0;
            flags_left_next = '0;
            tok1_next       = '0;
            dist_next       = '0;
            halted_next     = (cfg_data == '0);
            wp_next         = '0;
            acc_next        = '0;
            cnt_next        = '0;
            state_next      = S_IDLE;
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_FLAG;
            decoded_reg     <= SIZE_W'(1);
            produced_reg    <= '0;
            flag_bits_reg   <= '0;
            flags_left_reg  <= '0;
            tok1_reg        <= '0;
            dist_reg        <= '0;
            halted_reg      <= 1'b0;
            last_reg        <= 1'b0;
            len_reg         <= '0;
            wp_reg          <= '0;
            cnt_reg         <= '0;
            emit_final_reg  <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            decoded_reg     <= decoded_next;
            produced_reg    <= produced_next;
            flag_bits_reg   <= flag_bits_next;
            flags_left_reg  <= flags_left_next;
            tok1_reg        <= tok1_next;
            dist_reg        <= dist_next;
            halted_reg      <= halted_next;
            last_reg        <= last_next;
            len_reg         <= len_next;
            wp_reg          <= wp_next;
            cnt_reg         <= cnt_next;
            emit_final_reg  <= emit_final_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        acc_reg         <= acc_next;
        emit_status_reg <= emit_status_next;
        emit_done_reg   <= emit_done_next;
        m_tdata_reg     <= m_tdata_next;
        m_tlast_reg     <= m_tlast_next;
        m_tuser_reg     <= m_tuser_next;
    end

    // Checks
    `YAZ0_ASSERT_ALWAYS(a_produced_le_size, produced_reg <= decoded_reg || decoded_reg == '0, "produced count passed decoded size")
    `YAZ0_ASSERT_IMPLY(a_copy_len_nonzero, state_reg == S_COPY_RD || state_reg == S_COPY_WR, len_reg != '0, "copy running with zero length")
    `YAZ0_ASSERT_IMPLY(a_done_is_last, m_tvalid_reg && m_tuser_reg[0], m_tlast_reg, "stream_done on a result that is not the last")
    `YAZ0_ASSERT_IMPLY(a_bad_dist_empty, m_tvalid_reg && m_tuser_reg[2:1] == STAT_BAD_DIST, m_tdata_reg[67:64] == 4'd0 && m_tlast_reg, "bad-distance result carries data")
    `YAZ0_ASSERT_IMPLY(a_count_in_range, m_tvalid_reg, m_tdata_reg[67:64] <= BYTE_COUNT_W'(BYTES_PER_RESULT), "result byte count too large")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for yaz0_lz_decompressor: feeds Yaz0 payload streams byte by byte,
// predicts every decoded group in step with the input and checks each m_ transaction.
// Depends on yaz0_pkg and the decompressor RTL; reads no files.
module tb_top;
    import yaz0_pkg::*;

    localparam int          WIN          = WINDOW_BYTES_DEF;
    localparam int          GROUP        = BYTES_PER_RESULT_DEF;
    localparam logic [31:0] SIZE_MAX     = 32'hFFFF_FFFF;
    localparam int          TAIL_CYCLES  = 20;
    localparam int          STALL_CYCLES = 300;
    localparam int          MAX_REPORTS  = 100;

    // Parser position within the token stream
    typedef enum logic [1:0] {PH_FLAG, PH_ELEM, PH_DIST, PH_EXTRA} parse_phase_t;

    // One decoded output group as seen on the m_ side
    typedef struct {
        logic [63:0]  data;
        logic [3:0]   count;
        logic         last;
        logic         done;
        yaz0_status_t status;
    } out_group_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [SIZE_W-1:0]      cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_BYTE_W-1:0]   s_tdata   = '0;  // [7:0] in_byte
    logic                   s_tlast   = 1'b0;  // last_byte
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;  // [63:0] out_bytes, [67:64] byte_count
    logic                   m_tlast;  // run_last
    logic [M_TUSER_W-1:0]   m_tuser;  // [0] stream_done, [2:1] status

    // Predictor state: decode window, size register and parser
    logic [7:0]   window_mem [WIN];
    logic [31:0]  size_reg;
    logic [31:0]  made_cnt;
    parse_phase_t phase;
    logic [7:0]   flag_reg;
    logic [3:0]   flags_rem;
    logic [7:0]   tok_hi;
    logic [11:0]  copy_dist;
    logic         stopped;
    logic [63:0]  acc_data;
    int           acc_cnt;
    out_group_t   pending_groups [$];

    int mismatch_count = 0;
    int sent_items     = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_ask      = 0;
    int stall_seen     = 0;
    int stall_left     = 0;

    yaz0_lz_decompressor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void restart_stream(input logic [31:0] sz);
        size_reg  = sz;
        made_cnt  = '0;
        phase     = PH_FLAG;
        flag_reg  = '0;
        flags_rem = '0;
        tok_hi    = '0;
        copy_dist = '0;
        stopped   = (sz == 0);
    endfunction

    function automatic void push_group(input logic [63:0] d, input int cnt,
                                       input yaz0_status_t st);
        out_group_t g;
        g.data   = d;
        g.count  = cnt[3:0];
        g.last   = 1'b0;
        g.done   = 1'b0;
        g.status = st;
        pending_groups.push_back(g);
    endfunction

    function automatic void flush_group();
        if (acc_cnt != 0) begin
            push_group(acc_data, acc_cnt, STAT_OK);
            acc_data = '0;
            acc_cnt  = 0;
        end
    endfunction

    function automatic void put_out(input logic [7:0] v);
        window_mem[made_cnt % WIN] = v;
        made_cnt++;
        acc_data |= {56'd0, v} << (8 * acc_cnt);
        acc_cnt++;
        if (acc_cnt >= GROUP)
            flush_group();
    endfunction

    // Copy from the window, stopping at the programmed size
    function automatic void copy_run(input int len);
        logic [31:0] src;
        while (len != 0 && made_cnt < size_reg) begin
            src = made_cnt - {20'd0, copy_dist} - 32'd1;
            put_out(window_mem[src % WIN]);
            len--;
        end
        phase = (flags_rem != 0) ? PH_ELEM : PH_FLAG;
    endfunction

    // Advance the decoder by one accepted payload byte, queueing the groups it yields
    function automatic void decode_payload_byte(input logic [7:0] b, input logic last);
        int          base;
        logic        bad;
        logic        lit;
        logic [11:0] tok_gap;
        logic [3:0]  nib;
        if (stopped)
            return;
        base     = pending_groups.size();
        bad      = 1'b0;
        acc_data = '0;
        acc_cnt  = 0;
        case (phase)
            PH_FLAG: begin
                flag_reg  = b;
                flags_rem = FLAGS_PER_BYTE;
                phase     = PH_ELEM;
            end
            PH_ELEM: begin
                lit      = flag_reg[7];
                flag_reg = flag_reg << 1;
                if (flags_rem != 0)
                    flags_rem--;
                if (lit) begin
                    put_out(b);
                    phase = (flags_rem != 0) ? PH_ELEM : PH_FLAG;
                end else begin
                    tok_hi = b;
                    phase  = PH_DIST;
                end
            end
            PH_DIST: begin
                tok_gap = {tok_hi[3:0], b};
                nib     = tok_hi[7:4];
                // distance is checked before any extra length byte is taken
                if ({20'd0, tok_gap} >= made_cnt) begin
                    bad = 1'b1;
                end else begin
                    copy_dist = tok_gap;
                    if (nib == 0)
                        phase = PH_EXTRA;
                    else
                        copy_run(int'(nib) + int'(SHORT_LEN_BASE));
                end
            end
            default: copy_run(int'(b) + int'(LONG_LEN_BASE));
        endcase
        flush_group();

        // End conditions: size reached, bad distance, then early end of input
        if (made_cnt >= size_reg && pending_groups.size() > base) begin
            pending_groups[pending_groups.size() - 1].done = 1'b1;
            stopped = 1'b1;
        end else if (bad) begin
            push_group('0, 0, STAT_BAD_DIST);
            stopped = 1'b1;
        end else if (last) begin
            if (pending_groups.size() == base)
                push_group('0, 0, STAT_TRUNCATED);
            else
                pending_groups[pending_groups.size() - 1].status = STAT_TRUNCATED;
            stopped = 1'b1;
        end
        if (pending_groups.size() > base)
            pending_groups[pending_groups.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Compare every m_ transaction with the oldest predicted group
    always @(posedge aclk) begin : check_groups
        out_group_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_groups.size() == 0) begin
                flag_mismatch("unexpected group", m_tdata[63:0], '0);
            end else begin
                want = pending_groups.pop_front();
                if (m_tdata[63:0] !== want.data)
                    flag_mismatch("out_bytes", m_tdata[63:0], want.data);
                if (m_tdata[67:64] !== want.count)
                    flag_mismatch("byte_count", 64'(m_tdata[67:64]), 64'(want.count));
                if (m_tlast !== want.last)
                    flag_mismatch("run_last", 64'(m_tlast), 64'(want.last));
                if (m_tuser[0] !== want.done)
                    flag_mismatch("stream_done", 64'(m_tuser[0]), 64'(want.done));
                if (m_tuser[2:1] !== want.status)
                    flag_mismatch("status", 64'(m_tuser[2:1]), 64'(want.status));
            end
        end
    end

    // Result side: random idling, plus a long hold-off on request
    always @(posedge aclk) begin : drive_ready
        if (stall_ask != stall_seen) begin
            stall_seen = stall_ask;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic write_size(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        restart_stream(v);
    endtask

    // Offer one payload byte; valid stays high into the next call unless idle cycles are drawn
    task automatic send_item(input logic [7:0] b, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent_items++;
        decode_payload_byte(b, last);
    endtask

    // Drop valid, let every predicted group drain, then give the block time to settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_groups.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES)
            @(posedge aclk);
    endtask

    // Build a well-formed stream, optionally damage it, pick a size and send it
    task automatic send_stream(input int n_elem, input int lit_pct, input int far_pct,
                               input int long_pct, input bit clean);
        logic [7:0]  pay_q [$];
        logic [7:0]  flag;
        logic [7:0]  ext;
        logic [11:0] back_gap;
        logic [3:0]  nib;
        logic [31:0] sz;
        int          made;
        int          reach;
        int          cut;
        int          j;
        int          k;
        made = 0;
        flag = '0;
        for (k = 0; k < n_elem; k++) begin
            if (k % 8 == 0) begin
                for (j = 0; j < 8; j++)
                    flag[j] = ($urandom_range(99) < lit_pct);
                // nothing to refer back to yet
                if (k == 0)
                    flag[7] = 1'b1;
                pay_q.push_back(flag);
            end
            if (flag[7 - k % 8]) begin
                pay_q.push_back(8'($urandom));
                made++;
            end else begin
                reach = (made > WIN) ? WIN : made;
                if ($urandom_range(99) < far_pct)
                    back_gap = 12'($urandom_range(reach - 1));
                else
                    back_gap = 12'($urandom_range((reach > 16) ? 15 : reach - 1));
                if ($urandom_range(99) < long_pct) begin
                    nib = 4'd0;
                    ext = 8'($urandom_range(255));
                end else begin
                    nib = 4'($urandom_range(15));
                    ext = 8'($urandom_range(7));
                end
                pay_q.push_back({nib, back_gap[11:8]});
                pay_q.push_back(back_gap[7:0]);
                if (nib == 0) begin
                    pay_q.push_back(ext);
                    made += int'(ext) + int'(LONG_LEN_BASE);
                end else begin
                    made += int'(nib) + int'(SHORT_LEN_BASE);
                end
            end
        end

        // Broken sequences: one byte hit, cut short, or pure noise
        if (!clean) begin
            case ($urandom_range(9))
                0: pay_q[$urandom_range(pay_q.size() - 1)] = 8'($urandom);
                1: begin
                    cut = $urandom_range(1, pay_q.size());
                    while (pay_q.size() > cut)
                        void'(pay_q.pop_back());
                end
                2: foreach (pay_q[i]) pay_q[i] = 8'($urandom);
                default: ;
            endcase
        end

        if (clean) begin
            sz = SIZE_MAX;
        end else begin
            case ($urandom_range(9))
                0:          sz = SIZE_MAX;
                1, 2:       sz = $urandom_range(1, made);
                3, 4, 5, 6: sz = made;
                default:    sz = made + $urandom_range(1, 20);
            endcase
        end
        write_size(sz);
        for (k = 0; k < pay_q.size(); k++)
            send_item(pay_q[k], (k == pay_q.size() - 1) && (clean || $urandom_range(9) != 0));
        wait_idle();
    endtask

    // ---------------------------------------------------------------- tests

    // Size of one out of reset: first literal completes the stream, rest is dropped
    task automatic test_reset_size();
        send_item(8'h80, 1'b0);
        send_item(8'hA5, 1'b0);
        send_item(8'h3C, 1'b1);
        wait_idle();
    endtask

    // Literals at the byte extremes, short, long and maximum-length copies,
    // input ending on a step that yields groups
    task automatic test_element_kinds();
        logic [7:0] seq [15] = '{8'hF0, 8'h00, 8'hFF, 8'h5A, 8'h81, 8'hF0, 8'h00,
                                 8'h00, 8'h03, 8'hFF, 8'h10, 8'h02, 8'h00, 8'h00, 8'h00};
        int k;
        write_size(SIZE_MAX);
        for (k = 0; k < 15; k++)
            send_item(seq[k], k == 14);
        wait_idle();
    endtask

    // Reference before any output, far distance, long form: rejected before extra byte
    task automatic test_bad_distance();
        write_size(SIZE_MAX);
        send_item(8'h00, 1'b0);
        send_item(8'h0F, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h12, 1'b1);
        wait_idle();
    endtask

    // Copy clipped where the decoded size is reached
    task automatic test_size_clip();
        write_size(32'd5);
        send_item(8'h80, 1'b0);
        send_item(8'h11, 1'b0);
        send_item(8'h30, 1'b0);
        send_item(8'h00, 1'b0);
        wait_idle();
    endtask

    // Input ends on a flag byte: an empty truncation group
    task automatic test_truncated_flag();
        write_size(SIZE_MAX);
        send_item(8'h00, 1'b1);
        wait_idle();
    endtask

    // Zero size leaves the block halted
    task automatic test_zero_size();
        write_size(32'd0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_streams(input int until_items);
        while (sent_items < until_items)
            send_stream($urandom_range(1, 40), 50, 30, 5, 1'b0);
    endtask

    // Mostly long copies so the output runs well past one window and wraps
    task automatic test_window_wrap();
        send_stream(40, 10, 50, 100, 1'b1);
    endtask

    // Hold the result side off while bytes keep coming, so the input backs up
    task automatic test_output_stall();
        stall_ask++;
        send_stream(64, 70, 20, 0, 1'b1);
    endtask

    initial begin : run_tests
        int start;
        restart_stream(32'd1);
        repeat (4)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 32;
        recv_idle_pct = 59;
        test_reset_size();
        test_element_kinds();
        test_bad_distance();
        test_size_clip();
        test_truncated_flag();
        test_zero_size();

        start = sent_items;
        test_random_streams(start + 130);

        send_idle_pct = 59;
        recv_idle_pct = 32;
        test_window_wrap();
        test_random_streams(start + 270);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_stall();
        test_random_streams(start + 370);

        wait_idle();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #100ms;
        $display("status: fail");
        $finish;
    end

endmodule
